### src/skf_pkg.sv
package skf_pkg;

    localparam int GAIN_BITS = 30;
    localparam int DIV_GUARD = 4;
    localparam int QBITS     = GAIN_BITS + DIV_GUARD;
    localparam int ADDR_W    = 5;

    localparam logic [2:0] REG_STATE_GAIN    = 3'd0;
    localparam logic [2:0] REG_MEASURE_GAIN  = 3'd1;
    localparam logic [2:0] REG_PROCESS_NOISE = 3'd2;
    localparam logic [2:0] REG_MEASURE_NOISE = 3'd3;
    localparam logic [2:0] REG_INIT_ESTIMATE = 3'd4;
    localparam logic [2:0] REG_INIT_VARIANCE = 3'd5;

    localparam logic OP_FILTER  = 1'b0;
    localparam logic OP_RESTART = 1'b1;

    typedef logic [65:0] t_mag;

    typedef struct packed {
        logic [31:0] state_gain;
        logic [31:0] measure_gain;
        logic [31:0] process_noise;
        logic [31:0] measure_noise;
        logic [31:0] initial_estimate;
        logic [31:0] initial_variance;
    } t_cfg;

    typedef struct packed {
        logic        valid;
        logic        neg;
        logic        gain_shift;
        logic [32:0] a;
        logic [32:0] b;
    } t_mul_req;

    typedef struct packed {
        logic valid;
        logic neg;
        t_mag mag;
    } t_mul_rsp;

    typedef struct packed {
        logic        start;
        logic [31:0] num;
        logic [63:0] den;
    } t_div_req;

    typedef struct packed {
        logic        done;
        logic        ovf;
        logic [QBITS:0] q;
    } t_div_rsp;

    typedef struct packed {
        logic        saturated;
        logic        zero_divisor;
        logic [31:0] kalman_gain;
        logic [31:0] variance;
        logic [31:0] estimate;
    } t_result;

    typedef struct packed {
        logic        sat;
        logic [31:0] val;
    } t_clamp;

    function automatic logic [32:0] abs_s32(input logic [31:0] v);
        return v[31] ? (33'd0 - {v[31], v}) : {1'b0, v};
    endfunction

    function automatic t_clamp sat_s32(input logic neg, input t_mag mag);
        t_clamp c;
        c.sat = 1'b0;
        if (!neg) begin
            if (mag > 66'h7FFFFFFF) begin
                c.sat = 1'b1;
                c.val = 32'h7FFFFFFF;
            end else begin
                c.val = mag[31:0];
            end
        end else begin
            if (mag > 66'h80000000) begin
                c.sat = 1'b1;
                c.val = 32'h80000000;
            end else begin
                c.val = 32'd0 - mag[31:0];
            end
        end
        return c;
    endfunction

    function automatic t_clamp sat_u32(input logic neg, input t_mag mag);
        t_clamp c;
        c.sat = 1'b0;
        if (neg && (mag != '0)) begin
            c.sat = 1'b1;
            c.val = 32'd0;
        end else if (mag > 66'hFFFFFFFF) begin
            c.sat = 1'b1;
            c.val = 32'hFFFFFFFF;
        end else begin
            c.val = mag[31:0];
        end
        return c;
    endfunction

endpackage

### src/skf_mul.sv
module skf_mul #(
    parameter int FRAC_BITS = 16
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  skf_pkg::t_mul_req i_req,
    output skf_pkg::t_mul_rsp o_rsp
);
    import skf_pkg::*;

    localparam logic [66:0] RND_F = 67'd1 << (FRAC_BITS - 1);
    localparam logic [66:0] RND_G = 67'd1 << (GAIN_BITS - 1);

    logic        r_v1;
    logic        r_neg1;
    logic        r_gsh1;
    logic [65:0] r_prod;
    logic        r_v2;
    logic        r_neg2;
    t_mag        r_mag;

    logic [66:0] sum;
    logic [66:0] shf;

    // round half away from zero on the magnitude, then drop fraction bits
    always_comb begin
        sum = {1'b0, r_prod} + (r_gsh1 ? RND_G : RND_F);
        shf = r_gsh1 ? (sum >> GAIN_BITS) : (sum >> FRAC_BITS);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
        end else begin
            r_v1 <= i_req.valid;
            r_v2 <= r_v1;
        end
        r_prod <= i_req.a * i_req.b;
        r_neg1 <= i_req.neg;
        r_gsh1 <= i_req.gain_shift;
        r_mag  <= shf[65:0];
        r_neg2 <= r_neg1;
    end

    assign o_rsp.valid = r_v2;
    assign o_rsp.neg   = r_neg2;
    assign o_rsp.mag   = r_mag;

endmodule

### src/skf_div.sv
module skf_div (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  skf_pkg::t_div_req i_req,
    output skf_pkg::t_div_rsp o_rsp
);
    import skf_pkg::*;

    localparam int CNT_W = $clog2(QBITS);

    typedef enum logic [1:0] {D_IDLE, D_CHECK, D_RUN, D_ROUND} t_dstate;

    t_dstate           r_state;
    logic [31:0]       r_num;
    logic [63:0]       r_den;
    logic [63:0]       r_rem;
    logic [QBITS-1:0]  r_dvd;
    logic [QBITS-1:0]  r_q;
    logic [CNT_W-1:0]  r_cnt;
    logic              r_done;
    logic              r_ovf;
    logic [QBITS:0]    r_qout;

    logic [64:0] trial;
    logic [64:0] diff;
    logic        ge;
    logic        ovf;
    logic        rnd_up;

    always_comb begin
        trial  = {r_rem, r_dvd[QBITS-1]};
        diff   = trial - {1'b0, r_den};
        ge     = trial >= {1'b0, r_den};
        // quotient would not fit in QBITS bits
        ovf    = {36'd0, r_num} >= {r_den, 4'd0};
        rnd_up = {r_rem, 1'b0} >= {1'b0, r_den};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= D_IDLE;
            r_done  <= 1'b0;
        end else begin
            unique case (r_state)
                D_IDLE: begin
                    r_done <= 1'b0;
                    if (i_req.start) begin
                        r_num   <= i_req.num;
                        r_den   <= i_req.den;
                        r_state <= D_CHECK;
                    end
                end
                D_CHECK: begin
                    r_rem <= {{(64 - 32 + DIV_GUARD){1'b0}}, r_num[31:DIV_GUARD]};
                    r_dvd <= {r_num[DIV_GUARD-1:0], {GAIN_BITS{1'b0}}};
                    r_cnt <= CNT_W'(QBITS - 1);
                    r_q   <= '0;
                    if (ovf) begin
                        r_ovf   <= 1'b1;
                        r_qout  <= '0;
                        r_done  <= 1'b1;
                        r_state <= D_IDLE;
                    end else begin
                        r_ovf   <= 1'b0;
                        r_done  <= 1'b0;
                        r_state <= D_RUN;
                    end
                end
                D_RUN: begin
                    r_rem <= ge ? diff[63:0] : trial[63:0];
                    r_q   <= {r_q[QBITS-2:0], ge};
                    r_dvd <= {r_dvd[QBITS-2:0], 1'b0};
                    r_cnt <= r_cnt - 1'b1;
                    if (r_cnt == '0) begin
                        r_state <= D_ROUND;
                    end
                end
                D_ROUND: begin
                    r_qout  <= {1'b0, r_q} + {{QBITS{1'b0}}, rnd_up};
                    r_done  <= 1'b1;
                    r_state <= D_IDLE;
                end
                default: begin
                    r_done  <= 1'b0;
                    r_state <= D_IDLE;
                end
            endcase
        end
    end

    assign o_rsp.done = r_done;
    assign o_rsp.ovf  = r_ovf;
    assign o_rsp.q    = r_qout;

endmodule

### src/skf_seq.sv
module skf_seq #(
    parameter int FRAC_BITS = 16
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  skf_pkg::t_cfg    i_cfg,
    input  logic             i_in_valid,
    output logic             o_in_ready,
    input  logic             i_in_op,
    input  logic [31:0]      i_in_z,
    output logic             o_out_valid,
    input  logic             i_out_ready,
    output skf_pkg::t_result o_out
);
    import skf_pkg::*;

    localparam logic [31:0] P_RST = 32'd1 << FRAC_BITS;

    typedef enum logic [2:0] {S_IDLE, S_ISSUE, S_WAIT, S_DIVGO, S_DIVW, S_OUT} t_state;
    typedef enum logic [3:0] {
        ST_AX, ST_AA, ST_AP, ST_PH, ST_PHH, ST_HX, ST_GD, ST_GH, ST_OP
    } t_step;

    t_state      r_state;
    t_step       r_step;
    logic [31:0] r_x;
    logic [31:0] r_p;
    logic [31:0] r_aa;
    logic [31:0] r_ph;
    logic [31:0] r_z;
    logic [31:0] r_gain;
    logic [33:0] r_diff;
    logic [33:0] r_om;
    logic [63:0] r_den;
    logic        r_zdiv;
    logic        r_sat;
    logic        r_ovalid;
    t_result     r_out;

    t_mul_req mul_req;
    t_mul_rsp mul_rsp;
    t_div_req div_req;
    t_div_rsp div_rsp;

    t_clamp      c_s;
    t_clamp      c_u;
    t_clamp      c_g;
    logic [32:0] ph_mag;
    logic [32:0] n_pq_sum;
    logic [31:0] n_pp;
    logic [63:0] n_den;
    logic [33:0] n_diff;
    logic [33:0] n_om;
    logic [39:0] n_sum;
    logic [31:0] n_est;
    logic        n_est_sat;

    skf_mul #(.FRAC_BITS(FRAC_BITS)) u_mul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (mul_req),
        .o_rsp   (mul_rsp)
    );

    skf_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (div_req),
        .o_rsp   (div_rsp)
    );

    // operand selection for the shared multiplier
    always_comb begin
        mul_req.valid      = (r_state == S_ISSUE);
        mul_req.neg        = 1'b0;
        mul_req.gain_shift = 1'b0;
        mul_req.a          = '0;
        mul_req.b          = '0;
        unique case (r_step)
            ST_AX: begin
                mul_req.a   = abs_s32(i_cfg.state_gain);
                mul_req.b   = abs_s32(r_x);
                mul_req.neg = i_cfg.state_gain[31] ^ r_x[31];
            end
            ST_AA: begin
                mul_req.a = abs_s32(i_cfg.state_gain);
                mul_req.b = abs_s32(i_cfg.state_gain);
            end
            ST_AP: begin
                mul_req.a = {1'b0, r_aa};
                mul_req.b = {1'b0, r_p};
            end
            ST_PH: begin
                mul_req.a   = {1'b0, r_p};
                mul_req.b   = abs_s32(i_cfg.measure_gain);
                mul_req.neg = i_cfg.measure_gain[31];
            end
            ST_PHH: begin
                mul_req.a = abs_s32(r_ph);
                mul_req.b = abs_s32(i_cfg.measure_gain);
            end
            ST_HX: begin
                mul_req.a   = abs_s32(i_cfg.measure_gain);
                mul_req.b   = abs_s32(r_x);
                mul_req.neg = i_cfg.measure_gain[31] ^ r_x[31];
            end
            ST_GD: begin
                mul_req.a          = abs_s32(r_gain);
                mul_req.b          = r_diff[33] ? 33'(34'd0 - r_diff) : r_diff[32:0];
                mul_req.neg        = r_gain[31] ^ r_diff[33];
                mul_req.gain_shift = 1'b1;
            end
            ST_GH: begin
                mul_req.a   = abs_s32(r_gain);
                mul_req.b   = abs_s32(i_cfg.measure_gain);
                mul_req.neg = r_gain[31] ^ i_cfg.measure_gain[31];
            end
            ST_OP: begin
                mul_req.a          = r_om[33] ? 33'(34'd0 - r_om) : r_om[32:0];
                mul_req.b          = {1'b0, r_p};
                mul_req.neg        = r_om[33];
                mul_req.gain_shift = 1'b1;
            end
            default: ;
        endcase
    end

    assign ph_mag = abs_s32(r_ph);

    always_comb begin
        div_req.start = (r_state == S_DIVGO);
        div_req.num   = ph_mag[31:0];
        div_req.den   = n_den;
    end

    // results of the step that is finishing
    always_comb begin
        c_s      = sat_s32(mul_rsp.neg, mul_rsp.mag);
        c_u      = sat_u32(mul_rsp.neg, mul_rsp.mag);
        c_g      = sat_s32(r_ph[31], div_rsp.ovf ? '1 : t_mag'(div_rsp.q));
        n_pq_sum = {1'b0, c_u.val} + {1'b0, i_cfg.process_noise};
        n_pp     = n_pq_sum[32] ? 32'hFFFFFFFF : n_pq_sum[31:0];
        n_diff   = {{2{r_z[31]}}, r_z} - {{2{c_s.val[31]}}, c_s.val};
        n_om     = (34'd1 << GAIN_BITS) - {{2{c_s.val[31]}}, c_s.val};
        n_sum    = mul_rsp.neg ? ({{8{r_x[31]}}, r_x} - {1'b0, mul_rsp.mag[38:0]})
                               : ({{8{r_x[31]}}, r_x} + {1'b0, mul_rsp.mag[38:0]});
        n_est_sat = 1'b0;
        n_est     = n_sum[31:0];
        if (!n_sum[39] && (n_sum[38:31] != 8'h00)) begin
            n_est_sat = 1'b1;
            n_est     = 32'h7FFFFFFF;
        end else if (n_sum[39] && (n_sum[38:31] != 8'hFF)) begin
            n_est_sat = 1'b1;
            n_est     = 32'h80000000;
        end
    end

    // gain divisor p'*h*h + r, kept wide and never clamped
    assign n_den = (r_state == S_WAIT) ? (mul_rsp.mag[63:0] + {32'd0, i_cfg.measure_noise})
                                       : r_den;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_step   <= ST_AX;
            r_x      <= '0;
            r_p      <= P_RST;
            r_ovalid <= 1'b0;
        end else begin
            if (r_ovalid && i_out_ready && (r_state != S_OUT)) begin
                r_ovalid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (i_in_valid) begin
                        r_sat  <= 1'b0;
                        r_zdiv <= 1'b0;
                        r_gain <= '0;
                        if (i_in_op == OP_RESTART) begin
                            r_x     <= i_cfg.initial_estimate;
                            r_p     <= i_cfg.initial_variance;
                            r_state <= S_OUT;
                        end else begin
                            r_z     <= i_in_z;
                            r_step  <= ST_AX;
                            r_state <= S_ISSUE;
                        end
                    end
                end
                S_ISSUE: r_state <= S_WAIT;
                S_WAIT: begin
                    if (mul_rsp.valid) begin
                        unique case (r_step)
                            ST_AX: begin
                                r_x     <= c_s.val;
                                r_sat   <= r_sat | c_s.sat;
                                r_step  <= ST_AA;
                                r_state <= S_ISSUE;
                            end
                            ST_AA: begin
                                r_aa    <= c_u.val;
                                r_sat   <= r_sat | c_u.sat;
                                r_step  <= ST_AP;
                                r_state <= S_ISSUE;
                            end
                            ST_AP: begin
                                r_p     <= n_pp;
                                r_sat   <= r_sat | c_u.sat | n_pq_sum[32];
                                r_step  <= ST_PH;
                                r_state <= S_ISSUE;
                            end
                            ST_PH: begin
                                r_ph    <= c_s.val;
                                r_sat   <= r_sat | c_s.sat;
                                r_step  <= ST_PHH;
                                r_state <= S_ISSUE;
                            end
                            ST_PHH: begin
                                r_den <= n_den;
                                if (n_den == '0) begin
                                    r_zdiv  <= 1'b1;
                                    r_gain  <= '0;
                                    r_step  <= ST_HX;
                                    r_state <= S_ISSUE;
                                end else begin
                                    r_state <= S_DIVGO;
                                end
                            end
                            ST_HX: begin
                                r_diff  <= n_diff;
                                r_sat   <= r_sat | c_s.sat;
                                r_step  <= ST_GD;
                                r_state <= S_ISSUE;
                            end
                            ST_GD: begin
                                r_x     <= n_est;
                                r_sat   <= r_sat | n_est_sat;
                                r_step  <= ST_GH;
                                r_state <= S_ISSUE;
                            end
                            ST_GH: begin
                                r_om    <= n_om;
                                r_sat   <= r_sat | c_s.sat;
                                r_step  <= ST_OP;
                                r_state <= S_ISSUE;
                            end
                            ST_OP: begin
                                r_p     <= c_u.val;
                                r_sat   <= r_sat | c_u.sat;
                                r_state <= S_OUT;
                            end
                            default: r_state <= S_IDLE;
                        endcase
                    end
                end
                S_DIVGO: r_state <= S_DIVW;
                S_DIVW: begin
                    if (div_rsp.done) begin
                        r_gain  <= c_g.val;
                        r_sat   <= r_sat | c_g.sat;
                        r_step  <= ST_HX;
                        r_state <= S_ISSUE;
                    end
                end
                S_OUT: begin
                    if (!r_ovalid || i_out_ready) begin
                        r_ovalid           <= 1'b1;
                        r_out.estimate     <= r_x;
                        r_out.variance     <= r_p;
                        r_out.kalman_gain  <= r_gain;
                        r_out.zero_divisor <= r_zdiv;
                        r_out.saturated    <= r_sat;
                        r_state            <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_ovalid;
    assign o_out       = r_out;

    a_mul_only_when_waiting: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        mul_rsp.valid |-> (r_state == S_WAIT))
        else $error("multiplier result outside wait state");

    a_div_only_when_waiting: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_rsp.done |-> (r_state == S_DIVW))
        else $error("divider result outside wait state");

    a_restart_goes_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready && (i_in_op == OP_RESTART)) |=> (r_state == S_OUT))
        else $error("restart did not go straight to output");

    a_zero_div_gain: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == S_OUT) && r_zdiv) |-> (r_gain == '0))
        else $error("gain not zero on zero divisor");

endmodule

### src/scalar_kalman_filter.sv
// scalar kalman filter, one measurement per input beat
// input stream: s_axis_tdata carries the measurement, s_axis_tuser the operation
// (filter or restart). output stream: one beat per input beat with estimate,
// variance and gain in m_axis_tdata, the zero-divisor and saturation flags in
// m_axis_tuser. the apb port holds the six coefficient and initial registers;
// pready is always high and a write lands in the access cycle.
// a filter beat runs nine products on one shared 33x33 multiplier and the gain
// division (a 34-step restoring divider plus setup and rounding), then its
// result goes into the output register. with a zero gain divisor the division
// is skipped; a quotient that is plainly too large ends the division at the
// setup check. a restart beat goes from idle straight to the output state and
// from there into the output register.
// s_axis_tready is high only while the sequencer is idle, so one beat is in
// work at a time and the next beat can be taken in the cycle after the result
// is registered; a new beat is never taken before the last one is finished.
// the result sits in an output register: a stalled receiver does not stop the
// next beat being taken, but a finished beat waits in the output state until
// the previous one is taken. reset clears the estimate to zero, the variance to
// one and the registers to their defaults (a and h one, q 200, r 500).
module scalar_kalman_filter #(
    parameter int FRAC_BITS = 16
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       s_axis_tvalid,
    output logic                       s_axis_tready,
    input  logic [31:0]                s_axis_tdata,  // [31:0] measurement
    input  logic [0:0]                 s_axis_tuser,  // [0] operation
    output logic                       m_axis_tvalid,
    input  logic                       m_axis_tready,
    output logic [95:0]                m_axis_tdata,  // [31:0] estimate, [63:32] variance,
                                                      // [95:64] kalman_gain
    output logic [1:0]                 m_axis_tuser,  // [0] zero_divisor, [1] saturated
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [skf_pkg::ADDR_W-1:0] paddr,
    input  logic [31:0]                pwdata,
    output logic [31:0]                prdata,
    output logic                       pready
);
    import skf_pkg::*;

    localparam logic [63:0] ONE64   = 64'd1 << FRAC_BITS;
    localparam logic [63:0] Q_RST64 = 64'd200 << FRAC_BITS;
    localparam logic [63:0] R_RST64 = 64'd500 << FRAC_BITS;

    t_cfg        r_cfg;
    t_result     res;
    logic [2:0]  reg_idx;
    logic        wr_en;

    assign pready  = 1'b1;
    assign reg_idx = paddr[ADDR_W-1:2];
    assign wr_en   = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.state_gain       <= ONE64[31:0];
            r_cfg.measure_gain     <= ONE64[31:0];
            r_cfg.process_noise    <= Q_RST64[31:0];
            r_cfg.measure_noise    <= R_RST64[31:0];
            r_cfg.initial_estimate <= '0;
            r_cfg.initial_variance <= ONE64[31:0];
        end else if (wr_en) begin
            unique case (reg_idx)
                REG_STATE_GAIN:    r_cfg.state_gain       <= pwdata;
                REG_MEASURE_GAIN:  r_cfg.measure_gain     <= pwdata;
                REG_PROCESS_NOISE: r_cfg.process_noise    <= pwdata;
                REG_MEASURE_NOISE: r_cfg.measure_noise    <= pwdata;
                REG_INIT_ESTIMATE: r_cfg.initial_estimate <= pwdata;
                REG_INIT_VARIANCE: r_cfg.initial_variance <= pwdata;
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (reg_idx)
            REG_STATE_GAIN:    prdata = r_cfg.state_gain;
            REG_MEASURE_GAIN:  prdata = r_cfg.measure_gain;
            REG_PROCESS_NOISE: prdata = r_cfg.process_noise;
            REG_MEASURE_NOISE: prdata = r_cfg.measure_noise;
            REG_INIT_ESTIMATE: prdata = r_cfg.initial_estimate;
            REG_INIT_VARIANCE: prdata = r_cfg.initial_variance;
            default:           prdata = '0;
        endcase
    end

    skf_seq #(.FRAC_BITS(FRAC_BITS)) u_seq (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (r_cfg),
        .i_in_valid  (s_axis_tvalid),
        .o_in_ready  (s_axis_tready),
        .i_in_op     (s_axis_tuser[0]),
        .i_in_z      (s_axis_tdata),
        .o_out_valid (m_axis_tvalid),
        .i_out_ready (m_axis_tready),
        .o_out       (res)
    );

    assign m_axis_tdata = {res.kalman_gain, res.variance, res.estimate};
    assign m_axis_tuser = {res.saturated, res.zero_divisor};

endmodule
